// ===== rtl/core/ile_pkg.sv =====
// ile_pkg: shared constants, codes and controller/datapath interface types
// for the indexed list engine. No dependencies.

package ile_pkg;

  // list sizing
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int CMP_W    = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;
  localparam int DATA_W   = 32;

  // operation codes
  localparam logic [2:0] OP_READ        = 3'd0;
  localparam logic [2:0] OP_INSERT_AT   = 3'd1;
  localparam logic [2:0] OP_DELETE_AT   = 3'd2;
  localparam logic [2:0] OP_INSERT_HEAD = 3'd3;
  localparam logic [2:0] OP_INSERT_TAIL = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // value returned by a read outside the list
  localparam logic [DATA_W-1:0] RD_INVALID = '1;

  // work class of an accepted word
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_READ = 2'd1,
    KIND_INS  = 2'd2,
    KIND_DEL  = 2'd3
  } ile_kind_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;    // latch the input word and its decode
    logic rd_pos;    // memory read at the target position
    logic mv_rd;     // memory read of the next entry to move
    logic mv_wr;     // write the moved entry and step the cursor
    logic commit;    // final write / count update
    logic load_out;  // load the result register
  } ile_cmd_t;

  // datapath to controller status
  typedef struct packed {
    ile_kind_t kind;  // class of the latched word
    logic      more;  // entries left to move
  } ile_stat_t;

endpackage

// ===== rtl/core/ile_dp.sv =====
// ile_dp: datapath of the indexed list engine: input decode, list memory,
// move cursor, entry count and result register. Depends on ile_pkg.

module ile_dp
  import ile_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ile_cmd_t          cmd,
  input  logic [2:0]        in_op,
  input  logic [POS_W-1:0]  in_pos,
  input  logic [DATA_W-1:0] in_val,
  output ile_stat_t         stat,
  output logic [47:0]       out_data
);

  // list memory, undefined until written
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_r;

  // latched word
  ile_kind_t         kind_r;
  logic [IDX_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  logic [1:0]        st_r;
  logic [DATA_W-1:0] rdc_r;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  idx_r;
  logic [47:0]       out_data_r;

  // decode of the incoming word
  ile_kind_t         dec_kind;
  logic [IDX_W-1:0]  dec_pos;
  logic [1:0]        dec_st;
  logic [DATA_W-1:0] dec_rd;
  logic              pos_neg;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              pos_bad;
  logic              pos_over;
  logic              full;

  assign pos_neg  = in_pos[POS_W-1];
  assign pos_ext  = CMP_W'(in_pos[POS_W-2:0]);
  assign cnt_ext  = CMP_W'(count_r);
  assign pos_bad  = pos_neg || (pos_ext >= cnt_ext);
  assign pos_over = !pos_neg && (pos_ext > cnt_ext);
  assign full     = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    dec_kind = KIND_NONE;
    dec_pos  = '0;
    dec_st   = ST_DONE;
    dec_rd   = '0;
    case (in_op)
      OP_READ: begin
        if (pos_bad) begin
          dec_rd = RD_INVALID;
          dec_st = ST_RANGE;
        end else begin
          dec_kind = KIND_READ;
          dec_pos  = pos_ext[IDX_W-1:0];
        end
      end
      OP_INSERT_AT: begin
        if (pos_over) begin
          dec_st = ST_RANGE;
        end else if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_kind = KIND_INS;
          dec_pos  = pos_neg ? '0 : pos_ext[IDX_W-1:0];
        end
      end
      OP_DELETE_AT: begin
        if (pos_bad) begin
          dec_st = ST_RANGE;
        end else begin
          dec_kind = KIND_DEL;
          dec_pos  = pos_ext[IDX_W-1:0];
        end
      end
      OP_INSERT_HEAD: begin
        if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_kind = KIND_INS;
        end
      end
      OP_INSERT_TAIL: begin
        if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_kind = KIND_INS;
          dec_pos  = count_r[IDX_W-1:0];
        end
      end
      default: begin
        dec_st = ST_RANGE;
      end
    endcase
  end

  // latch the word at accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_NONE;
    end else if (cmd.accept) begin
      kind_r <= dec_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos_r <= dec_pos;
      val_r <= in_val;
      st_r  <= dec_st;
      rdc_r <= dec_rd;
    end
  end

  // move cursor: insert walks down from count, delete walks up from pos
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= (dec_kind == KIND_INS) ? count_r : CNT_W'(dec_pos);
    end else if (cmd.mv_wr) begin
      idx_r <= (kind_r == KIND_INS) ? idx_r - 1'b1 : idx_r + 1'b1;
    end
  end

  always_comb begin
    stat.kind = kind_r;
    if (kind_r == KIND_INS) begin
      stat.more = idx_r > CNT_W'(pos_r);
    end else begin
      stat.more = (idx_r + 1'b1) < count_r;
    end
  end

  // memory port addressing
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [CNT_W-1:0]  mv_src;

  assign mv_src  = (kind_r == KIND_INS) ? idx_r - 1'b1 : idx_r + 1'b1;
  assign rd_en   = cmd.rd_pos || cmd.mv_rd;
  assign rd_addr = cmd.rd_pos ? pos_r : mv_src[IDX_W-1:0];
  assign wr_en   = cmd.mv_wr || (cmd.commit && kind_r == KIND_INS);
  assign wr_addr = cmd.mv_wr ? idx_r[IDX_W-1:0] : pos_r;
  assign wr_data = cmd.mv_wr ? rdata_r : val_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      if (kind_r == KIND_INS) begin
        count_r <= count_r + 1'b1;
      end else if (kind_r == KIND_DEL) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // result register: read_value, status, entry_count from the lowest bit
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {7'd0, 7'(count_r), st_r,
                     (kind_r == KIND_READ) ? rdata_r : rdc_r};
    end
  end

  assign out_data = out_data_r;

  // an insert is only committed into a list with room
  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && kind_r == KIND_INS) |-> (count_r < CNT_W'(CAPACITY)))
    else $error("insert committed into full list");

  // a delete is only committed on a non-empty list
  a_del_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && kind_r == KIND_DEL) |-> (count_r != '0))
    else $error("delete committed on empty list");

  // every moved entry was read in the cycle before
  a_move_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mv_wr |-> $past(cmd.mv_rd))
    else $error("move write without preceding read");

endmodule

// ===== rtl/core/ile_ctrl.sv =====
// ile_ctrl: controller state machine of the indexed list engine; steps the
// datapath through decode, position read, entry moves, commit and result hand-off.
// Depends on ile_pkg.

module ile_ctrl
  import ile_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  ile_stat_t stat,
  output ile_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DISP   = 7'b0000010,
    S_READ   = 7'b0000100,
    S_MOVE   = 7'b0001000,
    S_MV_WR  = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.kind)
          KIND_READ: state_nxt = S_READ;
          KIND_INS:  state_nxt = S_MOVE;
          KIND_DEL:  state_nxt = S_MOVE;
          default:   state_nxt = S_DONE;
        endcase
        cmd.rd_pos = (stat.kind == KIND_READ);
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_MOVE: begin
        if (stat.more) begin
          cmd.mv_rd = 1'b1;
          state_nxt = S_MV_WR;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_MV_WR: begin
        cmd.mv_wr = 1'b1;
        state_nxt = S_MOVE;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result word valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  // result register is only overwritten once taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result overwritten before taken");

  // an accepted word is dispatched in the next cycle
  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_DISP))
    else $error("accepted word not dispatched");

  // a loaded result is offered in the next cycle
  a_offer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("loaded result not offered");

endmodule

// ===== rtl/core/indexed_list_engine.sv =====
// indexed_list_engine: top level of the indexed list engine, joining the
// controller and the datapath. Depends on ile_pkg, ile_ctrl and ile_dp.

// Ordered list of up to CAPACITY (64) signed 32-bit entries held in a
// single-port-write, single-port-read memory, one operation per input word
// and one result word per operation. Items are handled one at a time: an
// insert or delete does one move for each of the m entries that shift (count - pos
// for an insert, count - 1 - pos for a delete), and each moved entry needs
// one memory read and one write. The result register lets the next word be
// accepted while a result waits to be taken. No memory clearing pass runs
// after reset; the block is ready as soon as reset is released.

module indexed_list_engine
  import ile_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // opcode[2:0], position[10:3], value[42:11]
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_value[31:0], status[33:32],
                                  // entry_count[40:34]
);

  ile_cmd_t  cmd;
  ile_stat_t stat;

  // controller
  ile_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath
  ile_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_op    (in_tdata[2:0]),
    .in_pos   (in_tdata[10:3]),
    .in_val   (in_tdata[42:11]),
    .stat     (stat),
    .out_data (out_tdata)
  );

endmodule

// ===== tb/indexed_list_engine_checker.sv =====
`timescale 1ns / 1ps
// indexed_list_engine_checker: watches the word and result channels of the
// indexed list engine, keeps a shadow list, predicts and compares each result.
// Depends on ile_pkg.

module indexed_list_engine_checker
  import ile_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,    // opcode[2:0], position[10:3], value[42:11]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,   // read_value[31:0], status[33:32],
                                   // entry_count[40:34]
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic [1:0]        status;
    logic [6:0]        entry_count;
  } list_result_t;

  // shadow copy of the list and the results still owed by the block
  logic [DATA_W-1:0] shadow_entries [CAPACITY];
  int                shadow_count;
  list_result_t      owed_results [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // place a value before slot, later entries move up one
  function automatic logic [1:0] shadow_insert(input int slot,
                                               input logic [DATA_W-1:0] value);
    if (shadow_count >= CAPACITY)
      return ST_FULL;
    for (int i = shadow_count; i > slot; i--)
      shadow_entries[i] = shadow_entries[i-1];
    shadow_entries[slot] = value;
    shadow_count++;
    return ST_DONE;
  endfunction

  // apply one operation to the shadow list and build its result word
  function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                 input logic signed [POS_W-1:0] pos,
                                                 input logic [DATA_W-1:0] value);
    list_result_t res;
    int           p;
    res = '0;
    p = int'(pos);
    res.status = ST_DONE;
    case (op)
      OP_READ: begin
        if (p < 0 || p >= shadow_count) begin
          res.read_value = RD_INVALID;
          res.status = ST_RANGE;
        end else begin
          res.read_value = shadow_entries[p];
        end
      end
      OP_INSERT_AT: begin
        // range check comes ahead of the full check
        if (p > shadow_count)
          res.status = ST_RANGE;
        else
          res.status = shadow_insert((p < 0) ? 0 : p, value);
      end
      OP_DELETE_AT: begin
        if (p < 0 || p >= shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = p; i < shadow_count - 1; i++)
            shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      OP_INSERT_HEAD: res.status = shadow_insert(0, value);
      OP_INSERT_TAIL: res.status = shadow_insert(shadow_count, value);
      default:        res.status = ST_RANGE;
    endcase
    res.entry_count = shadow_count[6:0];
    return res;
  endfunction

  // result side first: a word leaving now belongs to an earlier input word
  always @(posedge clk) begin : monitor
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      owed_results.delete();
      shadow_count = 0;
      pending = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.read_value  = out_tdata[31:0];
        got.status      = out_tdata[33:32];
        got.entry_count = out_tdata[40:34];
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", out_tdata));
        end else begin
          want = owed_results.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %h, expected %h",
                                      got.read_value, want.read_value));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      got.status, want.status));
          if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      got.entry_count, want.entry_count));
          if (out_tdata[47:41] !== '0)
            report_mismatch($sformatf("pad bits %h not zero", out_tdata[47:41]));
        end
      end
      if (in_tvalid && in_tready)
        owed_results.push_back(apply_list_op(in_tdata[2:0], in_tdata[10:3],
                                             in_tdata[42:11]));
      pending = owed_results.size();
    end
  end

endmodule

// ===== tb/indexed_list_engine_tb.sv =====
`timescale 1ns / 1ps
// indexed_list_engine_tb: drives operation words into the indexed list engine
// with random gaps and stalls and gives the verdict. Depends on ile_pkg,
// indexed_list_engine and indexed_list_engine_checker.

module indexed_list_engine_tb
  import ile_pkg::*;
();

  localparam int HOLD_CYCLES  = 500;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 150;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 110;
  localparam logic [2:0] OP_FIRST_UNUSED = OP_INSERT_TAIL + 3'd1;

  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_SHRINK,
    MIX_BALANCED
  } op_mix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  int          fail_count;
  int          pending;
  int          hold_req = 0;
  int          hold_seen = 0;
  bit          calm = 1'b0;
  int          idle_cycles = 0;
  op_mix_t     mix;

  indexed_list_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  indexed_list_engine_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65)
      return 0;
    if (r < 92)
      return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [2:0] pick_op(input op_mix_t m);
    int r;
    int w_read;
    int w_del;
    r = $urandom_range(0, 99);
    if (r < 3)
      return 3'($urandom_range(int'(OP_FIRST_UNUSED), 7));
    case (m)
      MIX_GROW:   begin w_read = 10; w_del = 8;  end
      MIX_SHRINK: begin w_read = 25; w_del = 55; end
      default:    begin w_read = 30; w_del = 25; end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_read)
      return OP_READ;
    if (r < w_read + w_del)
      return OP_DELETE_AT;
    case ($urandom_range(0, 2))
      0:       return OP_INSERT_AT;
      1:       return OP_INSERT_HEAD;
      default: return OP_INSERT_TAIL;
    endcase
  endfunction

  // near the front, anywhere in the list, negative, or any byte
  function automatic logic signed [7:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      return 8'($urandom_range(0, 7));
    if (r < 75)
      return 8'($urandom_range(0, 66));
    if (r < 90)
      return 8'(-int'($urandom_range(1, 128)));
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85)
      return $urandom;
    case (r % 4)
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // offer one word and hold it until it is taken
  task automatic send_word(input logic [2:0] op, input logic signed [7:0] pos,
                           input logic [31:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 48'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, value, pos, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait for every owed result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  // result side: random stalls, calm stretches, and one long hold on request
  initial begin : receiver
    int stall;
    @(posedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corners, clamping, append by index, field extremes
    send_word(OP_READ,        8'sd0,   $urandom);
    send_word(OP_DELETE_AT,   8'sd0,   $urandom);
    send_word(OP_INSERT_AT,   8'sd1,   32'h1234_5678);
    send_word(OP_INSERT_AT,   -8'sd5,  32'h7fff_ffff);
    send_word(OP_INSERT_HEAD, 8'sd0,   32'h8000_0000);
    send_word(OP_INSERT_TAIL, 8'sd0,   32'hffff_ffff);
    send_word(OP_INSERT_AT,   8'sd3,   32'h0000_0000);
    send_word(OP_INSERT_AT,   8'sd1,   32'h5555_5555);
    send_word(OP_INSERT_AT,   8'sd6,   32'haaaa_aaaa);
    send_word(OP_READ,        8'sh80,  $urandom);
    send_word(OP_READ,        8'sd127, $urandom);
    send_word(OP_READ,        8'sd0,   $urandom);
    send_word(OP_READ,        8'sd4,   $urandom);
    send_word(OP_READ,        8'sd5,   $urandom);
    send_word(OP_DELETE_AT,   8'sd4,   $urandom);
    send_word(OP_DELETE_AT,   8'sd0,   $urandom);
    send_word(OP_DELETE_AT,   -8'sd1,  $urandom);
    send_word(OP_DELETE_AT,   8'sd3,   $urandom);
    send_word(OP_FIRST_UNUSED,        8'sd0, $urandom);
    send_word(OP_FIRST_UNUSED + 3'd1, 8'sd1, $urandom);
    send_word(OP_FIRST_UNUSED + 3'd2, 8'sd2, $urandom);
    send_word(OP_READ,        8'sd1,   $urandom);

    // fill past capacity, then every insert form against a full list
    repeat (CAPACITY + 2) send_word(OP_INSERT_TAIL, pick_position(), pick_value());
    send_word(OP_INSERT_HEAD, 8'sd0,   pick_value());
    send_word(OP_INSERT_AT,   8'sd0,   pick_value());
    send_word(OP_INSERT_AT,   -8'sd3,  pick_value());
    send_word(OP_INSERT_AT,   8'sd64,  pick_value());
    send_word(OP_INSERT_AT,   8'sd65,  pick_value());
    send_word(OP_INSERT_AT,   8'sd127, pick_value());
    send_word(OP_READ,        8'sd63,  $urandom);
    send_word(OP_READ,        8'sd64,  $urandom);
    send_word(OP_DELETE_AT,   8'sd63,  $urandom);
    send_word(OP_INSERT_AT,   8'sd63,  pick_value());
    send_word(OP_READ,        8'sd63,  $urandom);

    // random phases that swing the list between empty and full
    for (int phase = 0; phase < PHASES; phase++) begin
      mix = op_mix_t'(phase % 3);
      calm = (phase == 4);
      if (phase == 6)
        drain_results();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 20)
          hold_req++;
        send_word(pick_op(mix), pick_position(), pick_value());
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
